>>> rtl/core/som_pkg.sv
// shared types, constants and lookup tables of the self-organizing map block
`default_nettype none
package som_pkg;

    localparam int SOM_MAX_NODES    = 256;
    localparam int SOM_MAX_FEATURES = 16;
    localparam int SOM_VALUE_BITS   = 16;
    localparam int SOM_MAP_DIMS     = 2;

    localparam int SOM_ROOT_W = 44;
    localparam int SOM_NUM_W  = 31;
    localparam int SOM_DEN_W  = 32;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_UPDATE = 2'd3;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [2:0] REG_FEATURES = 3'd0;
    localparam logic [2:0] REG_SIZE_X   = 3'd1;
    localparam logic [2:0] REG_SIZE_Y   = 3'd2;
    localparam logic [2:0] REG_RATE     = 3'd3;
    localparam logic [2:0] REG_RADIUS   = 3'd4;

    localparam longint SOM_VAL_HI_L = (64'sd1 <<< (SOM_VALUE_BITS - 1)) - 1;
    localparam logic signed [19:0] SOM_VAL_HI = 20'(SOM_VAL_HI_L);
    localparam logic signed [19:0] SOM_VAL_LO = 20'(-SOM_VAL_HI_L - 1);

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        node;
        logic [3:0]        feat;
        logic signed [15:0] value;
        logic              last;
        logic [7:0]        bx;
        logic [7:0]        by;
        logic              node_ok;
        logic              feat_ok;
    } t_op;

    typedef struct packed {
        logic [4:0]  features;
        logic [8:0]  size_x;
        logic [8:0]  size_y;
        logic [15:0] rate;
        logic [15:0] radius;
    } t_cfg;

    function automatic logic signed [15:0] clamp_val(input logic signed [19:0] v);
        logic signed [19:0] c;
        c = v;
        if (c > SOM_VAL_HI) c = SOM_VAL_HI;
        if (c < SOM_VAL_LO) c = SOM_VAL_LO;
        return c[15:0];
    endfunction

    function automatic logic [16:0] exp_whole(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd24109;
            4'd2:  r = 17'd8869;
            4'd3:  r = 17'd3263;
            4'd4:  r = 17'd1200;
            4'd5:  r = 17'd442;
            4'd6:  r = 17'd162;
            4'd7:  r = 17'd60;
            4'd8:  r = 17'd22;
            4'd9:  r = 17'd8;
            4'd10: r = 17'd3;
            4'd11: r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_part(input logic [3:0] k);
        logic [16:0] r;
        case (k)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd61565;
            4'd2:  r = 17'd57835;
            4'd3:  r = 17'd54331;
            4'd4:  r = 17'd51040;
            4'd5:  r = 17'd47947;
            4'd6:  r = 17'd45042;
            4'd7:  r = 17'd42313;
            4'd8:  r = 17'd39750;
            4'd9:  r = 17'd37341;
            4'd10: r = 17'd35079;
            4'd11: r = 17'd32954;
            4'd12: r = 17'd30957;
            4'd13: r = 17'd29081;
            4'd14: r = 17'd27319;
            default: r = 17'd25664;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/som_front.sv
// input stage: decodes and range-checks beats and queues them for the engine
`default_nettype none
module som_front
    import som_pkg::*;
#(
    parameter int MAX_NODES    = SOM_MAX_NODES,
    parameter int MAX_FEATURES = SOM_MAX_FEATURES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             o_op_valid,
    output t_op              o_op,
    input  wire logic        i_op_pop
);

    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_op        dec;
    logic       push;

    always_comb begin
        dec.cmd     = s_axis_tuser;
        dec.node    = s_axis_tdata[7:0];
        dec.feat    = s_axis_tdata[11:8];
        dec.value   = s_axis_tdata[27:12];
        dec.last    = s_axis_tlast;
        dec.bx      = s_axis_tdata[35:28];
        dec.by      = s_axis_tdata[43:36];
        dec.node_ok = int'(s_axis_tdata[7:0]) < MAX_NODES;
        dec.feat_ok = int'(s_axis_tdata[11:8]) < MAX_FEATURES;
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_op_valid    = (r_cnt != 2'd0);
    assign o_op          = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_op_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_op_pop};
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/som_sqrt.sv
// iterative integer square root, one result bit per cycle
`default_nettype none
module som_sqrt
    import som_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [SOM_ROOT_W-1:0]   i_value,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [SOM_ROOT_W/2-1:0]      o_root
);

    localparam int HW = SOM_ROOT_W / 2;
    localparam int RW = HW + 2;
    localparam int CNW = $clog2(HW + 1);

    logic [SOM_ROOT_W-1:0] r_val;
    logic [RW-1:0]         r_rem;
    logic [HW-1:0]         r_root;
    logic [CNW-1:0]        r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [RW-1:0]         rem_sh;
    logic [RW-1:0]         trial;

    assign rem_sh = {r_rem[HW-1:0], r_val[SOM_ROOT_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[SOM_ROOT_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[HW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[HW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(HW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/som_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module som_div
    import som_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [SOM_NUM_W-1:0] i_num,
    input  wire logic [SOM_DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [SOM_NUM_W-1:0]      o_quot
);

    localparam int CNW = $clog2(SOM_NUM_W + 1);

    logic [SOM_NUM_W-1:0] r_num;
    logic [SOM_NUM_W-1:0] r_quot;
    logic [SOM_DEN_W-1:0] r_den;
    logic [SOM_DEN_W:0]   r_rem;
    logic [CNW-1:0]       r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [SOM_DEN_W:0]   rem_sh;

    assign rem_sh = {r_rem[SOM_DEN_W-1:0], r_num[SOM_NUM_W-1]};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[SOM_NUM_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem  <= rem_sh - {1'b0, r_den};
                    r_quot <= {r_quot[SOM_NUM_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_quot <= {r_quot[SOM_NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(SOM_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/som_back.sv
// execution engine: weight memory, best-match search and neighborhood update
`default_nettype none
module som_back
    import som_pkg::*;
#(
    parameter int MAX_NODES    = SOM_MAX_NODES,
    parameter int MAX_FEATURES = SOM_MAX_FEATURES,
    parameter int MAP_DIMS     = SOM_MAP_DIMS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_op_valid,
    input  wire t_op         i_op,
    output logic             o_op_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_read_value,
    output logic [7:0]       o_match_index,
    output logic [7:0]       o_match_x,
    output logic [7:0]       o_match_y,
    output logic [17:0]      o_match_distance
);

    localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW   = $clog2(MAX_NODES + 1);
    localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int FCW   = $clog2(MAX_FEATURES + 1);
    localparam int DEPTH = MAX_NODES * MAX_FEATURES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (NW > 8) ? NW : 8;
    localparam int DSW   = 2 * CW + 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_WR    = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_RWAIT = 5'd3;
    localparam logic [4:0] S_SMP   = 5'd4;
    localparam logic [4:0] S_SRD   = 5'd5;
    localparam logic [4:0] S_SDAT  = 5'd6;
    localparam logic [4:0] S_SMUL  = 5'd7;
    localparam logic [4:0] S_SACC  = 5'd8;
    localparam logic [4:0] S_SCMP  = 5'd9;
    localparam logic [4:0] S_SQGO  = 5'd10;
    localparam logic [4:0] S_SQW   = 5'd11;
    localparam logic [4:0] S_EMIT  = 5'd12;
    localparam logic [4:0] S_UNODE = 5'd13;
    localparam logic [4:0] S_UDX   = 5'd14;
    localparam logic [4:0] S_UDY   = 5'd15;
    localparam logic [4:0] S_UCMP  = 5'd16;
    localparam logic [4:0] S_URT   = 5'd17;
    localparam logic [4:0] S_UDV   = 5'd18;
    localparam logic [4:0] S_UDEC  = 5'd19;
    localparam logic [4:0] S_UK    = 5'd20;
    localparam logic [4:0] S_UFRD  = 5'd21;
    localparam logic [4:0] S_UFDAT = 5'd22;
    localparam logic [4:0] S_UFMUL = 5'd23;
    localparam logic [4:0] S_UFWR  = 5'd24;
    localparam logic [4:0] S_UNEXT = 5'd25;

    logic [4:0]         r_state;
    logic [4:0]         n_state;
    t_op                r_op;
    logic [NW-1:0]      r_i;
    logic [FW-1:0]      r_f;
    logic [CW-1:0]      r_cx;
    logic [CW-1:0]      r_cy;
    logic [39:0]        r_sum;
    logic [39:0]        r_best;
    logic [NW-1:0]      r_bidx;
    logic [CW-1:0]      r_bx;
    logic [CW-1:0]      r_by;
    logic signed [16:0] r_diff;
    logic [33:0]        r_sq;
    logic signed [15:0] r_w;
    logic signed [CW:0] r_dx;
    logic signed [CW:0] r_dy;
    logic [DSW-1:0]     r_dsq;
    logic [SOM_NUM_W-1:0] r_t8;
    logic [16:0]        r_infl;
    logic [16:0]        r_k;
    logic signed [34:0] r_p;
    logic [15:0]        r_rd;
    logic [17:0]        r_dist;
    logic [1:0]         r_ekind;

    logic               r_ovalid;
    logic [1:0]         r_okind;
    logic [15:0]        r_oread;
    logic [7:0]         r_oidx;
    logic [7:0]         r_ox;
    logic [7:0]         r_oy;
    logic [17:0]        r_odist;

    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_mem_rd;
    logic signed [15:0] r_samp [MAX_FEATURES];

    logic [FCW-1:0]     nf;
    logic [8:0]         sxs;
    logic [8:0]         sys;
    logic [17:0]        prod;
    logic [NCW-1:0]     nn;
    logic [31:0]        r2;
    logic               last_f;
    logic               last_n;
    logic [AW-1:0]      node_addr;
    logic [AW-1:0]      op_addr;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic signed [15:0] mem_wdata;
    logic [DSW+15:0]    dsq_sh;
    logic               in_reach;
    logic               sq_start;
    logic [SOM_ROOT_W-1:0] sq_value;
    logic               sq_busy;
    logic               sq_done;
    logic [SOM_ROOT_W/2-1:0] sq_root;
    logic               dv_start;
    logic               dv_done;
    logic [SOM_NUM_W-1:0] dv_quot;
    logic signed [19:0] upd_sum;
    logic [33:0]        infl_prod;
    logic [32:0]        k_prod;
    logic [39:0]        sum_n;
    logic               emit_go;

    always_comb begin
        if (i_cfg.features == 5'd0) nf = FCW'(1);
        else if (int'(i_cfg.features) > MAX_FEATURES) nf = FCW'(MAX_FEATURES);
        else nf = FCW'(i_cfg.features);
        sxs = (i_cfg.size_x == 9'd0) ? 9'd1 : (i_cfg.size_x > 9'd256) ? 9'd256 : i_cfg.size_x;
        sys = (i_cfg.size_y == 9'd0) ? 9'd1 : (i_cfg.size_y > 9'd256) ? 9'd256 : i_cfg.size_y;
        prod = (MAP_DIMS == 2) ? 18'(sxs) * 18'(sys) : 18'(sxs);
        nn = (int'(prod) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(prod);
    end

    assign r2        = 32'(i_cfg.radius) * 32'(i_cfg.radius);
    assign last_f    = ((FCW'(r_f) + 1'b1) == nf);
    assign last_n    = ((NCW'(r_i) + 1'b1) == nn);
    assign node_addr = AW'(AW'(r_i) * AW'(MAX_FEATURES) + AW'(r_f));
    assign op_addr   = AW'(AW'(r_op.node) * AW'(MAX_FEATURES) + AW'(r_op.feat));
    assign dsq_sh    = {r_dsq, 16'b0};
    assign in_reach  = (64'(dsq_sh) < 64'(r2));
    assign upd_sum   = 20'(r_w) + 20'($signed(r_p[34:16]));
    assign infl_prod = exp_whole(r_t8[11:8]) * exp_part(r_t8[7:4]);
    assign k_prod    = r_infl * i_cfg.rate;
    assign sum_n     = r_sum + 40'(r_sq);
    assign emit_go   = !r_ovalid || i_ready;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = node_addr;
        mem_raddr = node_addr;
        mem_wdata = clamp_val(upd_sum);
        case (r_state)
            S_WR: begin
                mem_we    = r_op.node_ok && r_op.feat_ok;
                mem_waddr = op_addr;
                mem_wdata = clamp_val(20'(r_op.value));
            end
            S_RD: begin
                mem_re    = r_op.node_ok && r_op.feat_ok;
                mem_raddr = op_addr;
            end
            S_SRD, S_UFRD: mem_re = 1'b1;
            S_UFWR: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_mem_rd <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SMP && r_op.feat_ok) begin
            r_samp[r_op.feat[FW-1:0]] <= clamp_val(20'(r_op.value));
        end
    end

    assign sq_start = (r_state == S_SQGO) || (r_state == S_UCMP && in_reach);
    assign sq_value = (r_state == S_SQGO) ? SOM_ROOT_W'(r_best) : SOM_ROOT_W'(dsq_sh);
    assign dv_start = (r_state == S_URT) && sq_done;
    assign o_op_pop = (r_state == S_IDLE) && i_op_valid;

    som_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    som_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   ({sq_root[15:0], 15'b0}),
        .i_den   (r2),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    case (i_op.cmd)
                        CMD_WRITE:  n_state = S_WR;
                        CMD_READ:   n_state = S_RD;
                        CMD_SAMPLE: n_state = S_SMP;
                        default:    n_state = S_UNODE;
                    endcase
                end
            end
            S_WR:    n_state = S_IDLE;
            S_RD:    n_state = S_RWAIT;
            S_RWAIT: n_state = S_EMIT;
            S_SMP:   n_state = r_op.last ? S_SRD : S_IDLE;
            S_SRD:   n_state = S_SDAT;
            S_SDAT:  n_state = S_SMUL;
            S_SMUL:  n_state = S_SACC;
            S_SACC:  n_state = last_f ? S_SCMP : S_SRD;
            S_SCMP:  n_state = last_n ? S_SQGO : S_SRD;
            S_SQGO:  n_state = S_SQW;
            S_SQW:   n_state = sq_done ? S_EMIT : S_SQW;
            S_EMIT:  n_state = emit_go ? S_IDLE : S_EMIT;
            S_UNODE: n_state = S_UDX;
            S_UDX:   n_state = S_UDY;
            S_UDY:   n_state = S_UCMP;
            S_UCMP:  n_state = in_reach ? S_URT : S_UNEXT;
            S_URT:   n_state = sq_done ? S_UDV : S_URT;
            S_UDV:   n_state = dv_done ? S_UDEC : S_UDV;
            S_UDEC:  n_state = S_UK;
            S_UK:    n_state = S_UFRD;
            S_UFRD:  n_state = S_UFDAT;
            S_UFDAT: n_state = S_UFMUL;
            S_UFMUL: n_state = S_UFWR;
            S_UFWR:  n_state = last_f ? S_UNEXT : S_UFRD;
            S_UNEXT: n_state = last_n ? S_EMIT : S_UNODE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op <= i_op;
                r_i  <= '0;
                r_f  <= '0;
                r_cx <= '0;
                r_cy <= '0;
                r_sum  <= '0;
                r_best <= '1;
                r_bidx <= '0;
                r_bx   <= '0;
                r_by   <= '0;
            end
            S_RWAIT: begin
                r_rd    <= (r_op.node_ok && r_op.feat_ok) ? r_mem_rd : 16'd0;
                r_ekind <= KIND_READ;
            end
            S_SDAT: r_diff <= 17'(r_mem_rd) - 17'(r_samp[r_f]);
            S_SMUL: r_sq <= $unsigned(34'(r_diff) * 34'(r_diff));
            S_SACC: begin
                r_sum <= sum_n;
                if (!last_f) r_f <= r_f + 1'b1;
            end
            S_SCMP: begin
                if (r_sum < r_best) begin
                    r_best <= r_sum;
                    r_bidx <= r_i;
                    r_bx   <= r_cx;
                    r_by   <= r_cy;
                end
                r_sum <= '0;
                r_f   <= '0;
            end
            S_SQW: begin
                r_dist  <= (sq_root[SOM_ROOT_W/2-1:18] != '0) ? 18'h3FFFF : sq_root[17:0];
                r_ekind <= KIND_MATCH;
            end
            S_UNODE: begin
                r_dx <= $signed({1'b0, CW'(r_op.bx)}) - $signed({1'b0, r_cx});
                r_dy <= (MAP_DIMS == 2) ? $signed({1'b0, CW'(r_op.by)}) - $signed({1'b0, r_cy})
                                        : '0;
            end
            S_UDX: r_dsq <= DSW'($unsigned(DSW'(r_dx) * DSW'(r_dx)));
            S_UDY: r_dsq <= r_dsq + DSW'($unsigned(DSW'(r_dy) * DSW'(r_dy)));
            S_UDV: r_t8 <= dv_quot;
            S_UDEC: r_infl <= (r_t8[SOM_NUM_W-1:8] >= (SOM_NUM_W-8)'(12)) ? 17'd0
                                                                          : infl_prod[32:16];
            S_UK: begin
                r_k <= k_prod[32:16];
                r_f <= '0;
            end
            S_UFDAT: begin
                r_w    <= r_mem_rd;
                r_diff <= 17'(r_samp[r_f]) - 17'(r_mem_rd);
            end
            S_UFMUL: r_p <= $signed({1'b0, r_k}) * r_diff;
            S_UFWR: if (!last_f) r_f <= r_f + 1'b1;
            S_UNEXT: r_ekind <= KIND_DONE;
            default: ;
        endcase
        if ((r_state == S_SCMP || r_state == S_UNEXT) && !last_n) begin
            r_i <= r_i + 1'b1;
            if (MAP_DIMS == 2) begin
                if (int'(r_cx) == int'(sxs) - 1) begin
                    r_cx <= '0;
                    r_cy <= r_cy + 1'b1;
                end else begin
                    r_cx <= r_cx + 1'b1;
                end
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_go) begin
            r_okind <= r_ekind;
            r_oread <= (r_ekind == KIND_READ) ? r_rd : 16'd0;
            r_oidx  <= (r_ekind == KIND_MATCH) ? 8'(r_bidx) : 8'd0;
            r_ox    <= (r_ekind == KIND_MATCH) ? r_bx[7:0] : 8'd0;
            r_oy    <= (r_ekind == KIND_MATCH) ? r_by[7:0] : 8'd0;
            r_odist <= (r_ekind == KIND_MATCH) ? r_dist : 18'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && emit_go) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_kind           = r_okind;
    assign o_read_value     = r_oread;
    assign o_match_index    = r_oidx;
    assign o_match_x        = r_ox;
    assign o_match_y        = r_oy;
    assign o_match_distance = r_odist;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_start |-> (r2 != 32'd0))
        else $error("divide started with zero radius");

    a_root_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("square root restarted while busy");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_pop |=> (r_state != S_IDLE))
        else $error("command taken but engine stayed idle");

endmodule
`default_nettype wire

>>> rtl/core/som_best_match_and_weight_update.sv
// top level of the self-organizing map block: register port, front queue and engine
// usage:
//   s_axis carries commands: tuser is the command (write, read, sample, update),
//   tlast marks the final feature of a sample. m_axis carries results, tuser the kind.
//   a write or a sample beat without tlast gives no result; a read gives its weight;
//   the final sample beat gives the best-matching node; an update gives one done beat.
//   a search's time is set by the four-step walk per feature and node through the single
//   read port of the weight memory, one compare per node and the bit-serial square root;
//   an update's time is set by the walk over all nodes and, for each node in reach, by
//   the root and the 31-step divider.
//   one command is worked at a time; a two-beat queue in front keeps taking beats
//   meanwhile, and a result register lets the next command start while it waits.
//   a stalled m_axis only blocks the engine once the next result is ready.
//   registers are written over apb at byte address 4*i; pready is always high.
//   reset (synchronous, active low) empties the queue and result register and restores
//   register defaults; weights and sample entries stay undefined until written.
`default_nettype none
module som_best_match_and_weight_update
    import som_pkg::*;
#(
    parameter int MAX_NODES    = SOM_MAX_NODES,
    parameter int MAX_FEATURES = SOM_MAX_FEATURES,
    parameter int MAP_DIMS     = SOM_MAP_DIMS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // node_index, feature_index, value, bmu_x, bmu_y, zero pad
    input  wire logic [47:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_value, match_index, match_x, match_y, match_distance, zero pad
    output logic [63:0]      m_axis_tdata,
    // kind
    output logic [1:0]       m_axis_tuser
);

    t_cfg        r_cfg;
    logic        op_valid;
    t_op         op;
    logic        op_pop;
    logic [1:0]  kind;
    logic [15:0] read_value;
    logic [7:0]  match_index;
    logic [7:0]  match_x;
    logic [7:0]  match_y;
    logic [17:0] match_distance;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.features <= 5'd16;
            r_cfg.size_x   <= 9'd16;
            r_cfg.size_y   <= 9'd16;
            r_cfg.rate     <= 16'd6554;
            r_cfg.radius   <= 16'd1024;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_FEATURES: r_cfg.features <= pwdata[4:0];
                REG_SIZE_X:   r_cfg.size_x   <= pwdata[8:0];
                REG_SIZE_Y:   r_cfg.size_y   <= pwdata[8:0];
                REG_RATE:     r_cfg.rate     <= pwdata[15:0];
                REG_RADIUS:   r_cfg.radius   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FEATURES: prdata = {27'd0, r_cfg.features};
            REG_SIZE_X:   prdata = {23'd0, r_cfg.size_x};
            REG_SIZE_Y:   prdata = {23'd0, r_cfg.size_y};
            REG_RATE:     prdata = {16'd0, r_cfg.rate};
            REG_RADIUS:   prdata = {16'd0, r_cfg.radius};
            default:      prdata = 32'd0;
        endcase
    end

    som_front #(
        .MAX_NODES    (MAX_NODES),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_op_valid    (op_valid),
        .o_op          (op),
        .i_op_pop      (op_pop)
    );

    som_back #(
        .MAX_NODES    (MAX_NODES),
        .MAX_FEATURES (MAX_FEATURES),
        .MAP_DIMS     (MAP_DIMS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_op_valid       (op_valid),
        .i_op             (op),
        .o_op_pop         (op_pop),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_kind           (kind),
        .o_read_value     (read_value),
        .o_match_index    (match_index),
        .o_match_x        (match_x),
        .o_match_y        (match_y),
        .o_match_distance (match_distance)
    );

    assign m_axis_tuser = kind;
    assign m_axis_tdata = {6'd0, match_distance, match_y, match_x, match_index, read_value};

endmodule
`default_nettype wire

>>> tb/som_checker.sv
// checker of the self-organizing map block: predicts every result beat and compares it
`timescale 1ns / 1ps
module som_checker
    import som_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] read_value;
        logic [7:0]  match_index;
        logic [7:0]  match_x;
        logic [7:0]  match_y;
        logic [17:0] match_distance;
    } t_som_result;

    t_som_result result_q[$];

    logic signed [15:0] weight_mem [0:4095];
    logic signed [15:0] sample_mem [0:15];
    logic [4:0]  cfg_features;
    logic [8:0]  cfg_size_x;
    logic [8:0]  cfg_size_y;
    logic [15:0] cfg_rate;
    logic [15:0] cfg_radius;

    longint unsigned exp_whole_tab [0:11] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
    };
    longint unsigned exp_part_tab [0:15] = '{
        65536, 61565, 57835, 54331, 51040, 47947, 45042, 42313,
        39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664
    };

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int clip_side(input logic [8:0] v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic int active_features();
        if (cfg_features < 1) return 1;
        if (cfg_features > 16) return 16;
        return int'(cfg_features);
    endfunction

    function automatic int active_nodes();
        int n;
        n = clip_side(cfg_size_x) * clip_side(cfg_size_y);
        return (n > 256) ? 256 : n;
    endfunction

    function automatic logic signed [15:0] saturate16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch in %s: got %0d, want %0d", what, got, want);
        o_fail_count++;
    endtask

    task automatic search_best(output t_som_result res);
        longint unsigned best;
        longint unsigned sum;
        longint dv;
        longint unsigned root;
        int best_i;
        int nf;
        int nn;
        int sx;
        best   = (64'd1 << 40) - 1;
        best_i = 0;
        nf = active_features();
        nn = active_nodes();
        sx = clip_side(cfg_size_x);
        for (int i = 0; i < nn; i++) begin
            sum = 0;
            for (int f = 0; f < nf; f++) begin
                dv = longint'(weight_mem[i * 16 + f]) - longint'(sample_mem[f]);
                sum += longint'(dv * dv);
            end
            if (sum < best) begin
                best   = sum;
                best_i = i;
            end
        end
        root = int_root(best);
        res.kind           = KIND_MATCH;
        res.read_value     = '0;
        res.match_index    = best_i[7:0];
        res.match_x        = 8'(best_i % sx);
        res.match_y        = 8'(best_i / sx);
        res.match_distance = (root > 262143) ? 18'h3ffff : root[17:0];
    endtask

    task automatic pull_neighbours(input logic [7:0] bx, input logic [7:0] by);
        longint r2;
        longint dx;
        longint dy;
        longint dsq;
        longint d8;
        longint t8;
        longint n;
        longint dec;
        longint k;
        longint p;
        longint step;
        int nf;
        int nn;
        int sx;
        nf = active_features();
        nn = active_nodes();
        sx = clip_side(cfg_size_x);
        r2 = longint'(cfg_radius) * longint'(cfg_radius);
        for (int i = 0; i < nn; i++) begin
            dx  = longint'(bx) - longint'(i % sx);
            dy  = longint'(by) - longint'(i / sx);
            dsq = dx * dx + dy * dy;
            if (dsq * 65536 >= r2) continue;
            d8  = longint'(int_root(longint'(dsq) << 16));
            t8  = d8 * 32768 / r2;
            n   = t8 >> 8;
            dec = (n >= 12) ? 0 : longint'((exp_whole_tab[n] * exp_part_tab[(t8 >> 4) & 15]) >> 16);
            k   = (dec * longint'(cfg_rate)) >> 16;
            for (int f = 0; f < nf; f++) begin
                p = k * (longint'(sample_mem[f]) - longint'(weight_mem[i * 16 + f]));
                step = (p >= 0) ? (p >> 16) : -((-p + 65535) >> 16);
                weight_mem[i * 16 + f] = saturate16(longint'(weight_mem[i * 16 + f]) + step);
            end
        end
    endtask

    task automatic predict_beat();
        t_som_result res;
        logic [7:0]  node;
        logic [3:0]  feat;
        logic signed [15:0] val;
        logic [7:0]  bx;
        logic [7:0]  by;
        node = s_axis_tdata[7:0];
        feat = s_axis_tdata[11:8];
        val  = s_axis_tdata[27:12];
        bx   = s_axis_tdata[35:28];
        by   = s_axis_tdata[43:36];
        res.kind = KIND_READ;
        res.read_value = '0;
        res.match_index = '0;
        res.match_x = '0;
        res.match_y = '0;
        res.match_distance = '0;
        case (s_axis_tuser)
            CMD_WRITE: weight_mem[{node, feat}] = val;
            CMD_READ: begin
                res.read_value = weight_mem[{node, feat}];
                result_q.push_back(res);
            end
            CMD_SAMPLE: begin
                sample_mem[feat] = val;
                if (s_axis_tlast) begin
                    search_best(res);
                    result_q.push_back(res);
                end
            end
            default: begin
                pull_neighbours(bx, by);
                res.kind = KIND_DONE;
                result_q.push_back(res);
            end
        endcase
    endtask

    task automatic compare_beat();
        t_som_result want;
        if (result_q.size() == 0) begin
            report("unexpected result beat kind", m_axis_tuser, -1);
            return;
        end
        want = result_q.pop_front();
        o_checked++;
        if (m_axis_tuser != want.kind) report("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[15:0] != want.read_value)
            report("read_value", m_axis_tdata[15:0], want.read_value);
        if (m_axis_tdata[23:16] != want.match_index)
            report("match_index", m_axis_tdata[23:16], want.match_index);
        if (m_axis_tdata[31:24] != want.match_x)
            report("match_x", m_axis_tdata[31:24], want.match_x);
        if (m_axis_tdata[39:32] != want.match_y)
            report("match_y", m_axis_tdata[39:32], want.match_y);
        if (m_axis_tdata[57:40] != want.match_distance)
            report("match_distance", m_axis_tdata[57:40], want.match_distance);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_features = 5'd16;
            cfg_size_x   = 9'd16;
            cfg_size_y   = 9'd16;
            cfg_rate     = 16'd6554;
            cfg_radius   = 16'd1024;
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_FEATURES: cfg_features = pwdata[4:0];
                    REG_SIZE_X:   cfg_size_x   = pwdata[8:0];
                    REG_SIZE_Y:   cfg_size_y   = pwdata[8:0];
                    REG_RATE:     cfg_rate     = pwdata[15:0];
                    REG_RADIUS:   cfg_radius   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) compare_beat();
            if (s_axis_tvalid && s_axis_tready) predict_beat();
        end
        o_pending = result_q.size();
    end

endmodule

>>> tb/tb.sv
// testbench top of the self-organizing map block: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb;
    import som_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count;
    int pending;
    int checked;
    int cycles;
    int beats_sent;
    int settings_used;
    int stall_left;
    bit no_idle;
    bit written [0:4095];
    int nf_now;
    int nn_now;
    int sx_now;
    int sy_now;

    som_best_match_and_weight_update DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    som_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (no_idle || $urandom_range(99) < 75) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            stall_left = ($urandom_range(99) < 90) ? $urandom_range(0, 3)
                                                  : $urandom_range(10, 60);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 16'h7fff;
        if (r < 8) return 16'h8000;
        if (r < 12) return 16'h0000;
        if (r < 16) return 16'h1000;
        return 16'($urandom);
    endfunction

    task automatic send(input int cmd, input int node, input int feat,
                        input int val, input int last,
                        input int bx, input int by);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tdata  = {4'b0, 8'(by), 8'(bx), 16'(val), 4'(feat), 8'(node)};
        s_axis_tuser  = 2'(cmd);
        s_axis_tlast  = last[0];
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        beats_sent++;
        if (2'(cmd) == CMD_WRITE) written[{8'(node), 4'(feat)}] = 1'b1;
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] d);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = d;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic int clip(input int v, input int hi);
        if (v < 1) return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic set_map(input int feats, input int sx, input int sy,
                           input int rate, input int rad);
        wait_idle();
        apb_write(REG_FEATURES, feats);
        apb_write(REG_SIZE_X, sx);
        apb_write(REG_SIZE_Y, sy);
        apb_write(REG_RATE, rate);
        apb_write(REG_RADIUS, rad);
        settings_used++;
        nf_now = clip(feats & 31, 16);
        sx_now = clip(sx & 511, 256);
        sy_now = clip(sy & 511, 256);
        nn_now = (sx_now * sy_now > 256) ? 256 : sx_now * sy_now;
        no_idle = ($urandom_range(3) == 0);
        for (int n = 0; n < nn_now; n++)
            for (int f = 0; f < nf_now; f++)
                if (!written[n * 16 + f])
                    send(CMD_WRITE, n, f, pick_value(), 1'b0, $urandom, $urandom);
    endtask

    task automatic sample_run(input int len);
        for (int j = 0; j < len; j++) begin
            if ($urandom_range(99) < 8)
                send(CMD_SAMPLE, $urandom, $urandom, pick_value(), 1'b0, $urandom, $urandom);
            send(CMD_SAMPLE, $urandom, j, pick_value(), (j == len - 1), $urandom, $urandom);
        end
    endtask

    task automatic random_traffic(input int count, input int upd_pct);
        int stop_at;
        int r;
        logic [7:0] node;
        logic [3:0] feat;
        logic [7:0] bx;
        logic [7:0] by;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            r = $urandom_range(99);
            if ($urandom_range(99) < 2) wait_idle();
            if (r < 30) begin
                node = ($urandom_range(99) < 70) ? 8'($urandom_range(0, nn_now - 1))
                                                 : 8'($urandom);
                send(CMD_WRITE, node, $urandom, pick_value(), $urandom, $urandom, $urandom);
            end else if (r < 50) begin
                node = 8'($urandom);
                feat = 4'($urandom);
                if (!written[{node, feat}]) begin
                    node = 8'($urandom_range(0, nn_now - 1));
                    feat = 4'($urandom_range(0, nf_now - 1));
                end
                send(CMD_READ, node, feat, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 100 - upd_pct) begin
                sample_run(($urandom_range(99) < 85) ? nf_now : $urandom_range(1, nf_now));
            end else begin
                bx = ($urandom_range(99) < 80) ? 8'($urandom_range(0, sx_now - 1))
                                               : 8'($urandom);
                by = ($urandom_range(99) < 80) ? 8'($urandom_range(0, (nn_now - 1) / sx_now))
                                               : 8'($urandom);
                send(CMD_UPDATE, $urandom, $urandom, $urandom, $urandom, bx, by);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        no_idle       = 1'b0;
        cycles        = 0;
        beats_sent    = 0;
        settings_used = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int f = 0; f < 16; f++)
            send(CMD_SAMPLE, 8'hff, f, pick_value(), 1'b0, 8'h00, 8'hff);

        // wide one-feature map, then directed corners
        set_map(1, 256, 1, 65535, 1024);
        send(CMD_WRITE, 0, 0, 16'h7fff, 1'b0, 0, 0);
        send(CMD_WRITE, 1, 0, 16'h8000, 1'b0, 0, 0);
        send(CMD_WRITE, 255, 15, 16'hffff, 1'b1, 8'hff, 8'hff);
        send(CMD_READ, 0, 0, 0, 1'b0, 0, 0);
        send(CMD_READ, 1, 0, 0, 1'b0, 0, 0);
        send(CMD_READ, 255, 15, 0, 1'b0, 0, 0);
        send(CMD_SAMPLE, 0, 0, 16'h8000, 1'b1, 0, 0);
        send(CMD_SAMPLE, 0, 0, 16'h7fff, 1'b1, 0, 0);
        send(CMD_UPDATE, 0, 0, 0, 1'b0, 0, 0);
        send(CMD_UPDATE, 0, 0, 0, 1'b0, 8'hff, 8'hff);
        send(CMD_READ, 1, 0, 0, 1'b0, 0, 0);
        random_traffic(40, 5);

        // out-of-range register values and full-map radius
        set_map(0, 257, 511, 0, 65535);
        send(CMD_UPDATE, 0, 0, 0, 1'b0, 8'd128, 0);
        random_traffic(40, 5);

        // single node, zero radius
        set_map(31, 1, 0, 65535, 0);
        send(CMD_UPDATE, 0, 0, 0, 1'b0, 0, 0);
        random_traffic(60, 15);

        set_map(16, 2, 2, 32768, 300);
        random_traffic(100, 10);

        for (int p = 0; p < 10; p++) begin
            set_map($urandom_range(1, 16), $urandom_range(1, 5), $urandom_range(1, 5),
                    $urandom_range(0, 65535),
                    ($urandom_range(99) < 70) ? $urandom_range(0, 1536)
                                              : $urandom_range(0, 65535));
            random_traffic(95, 12);
        end

        wait_idle();
        repeat (60) @(negedge i_clk);
        $display("sent %0d command beats over %0d register settings", beats_sent, settings_used);
        $display("checked %0d result beats (reads, best matches, updates)", checked);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
